[hw/rtl/cke_pkg.sv]
package cke_pkg;

	// sequence store geometry
	localparam int SEQ_WORDS  = 4096;
	localparam int SEQ_ADDR_W = $clog2(SEQ_WORDS);
	localparam int WORD_W     = 32;
	localparam int KMER_W     = 64;
	localparam int OFFSET_W   = 17;
	localparam int SYM_W      = 4;
	localparam int LEN_W      = 6;
	localparam int MAX_SYM    = 8;

	// bit position of the first symbol: offset times at most eight bits
	localparam int BITPOS_W = OFFSET_W + $clog2(MAX_SYM) + 1;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_SYMBOL_BITS = 2'd0,
		CFG_KMER_LENGTH = 2'd1,
		CFG_KMER_MASK   = 2'd2
	} cfg_index_t;

	// item kinds
	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	// register reset values
	localparam logic [SYM_W-1:0]  SYMBOL_BITS_RST = 4'd2;
	localparam logic [LEN_W-1:0]  KMER_LENGTH_RST = 6'd31;
	localparam logic [KMER_W-1:0] KMER_MASK_RST   = 64'hFFFF_FFFF_FFFF_FFFC;

endpackage

[hw/rtl/cke_ram.sv]
module cke_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/canonical_kmer_extract.sv]
// Canonical k-mer lookup over a packed sequence store of 32-bit words.
// Input items are accepted at each rising edge with start high and busy low;
// busy never rises, so one item can be accepted in every cycle.
// action 0 writes word_data at word_index; it gives no result.
// action 1 queries the k-mer that starts at symbol_offset; the result shows
// on canonical_kmer with done high for exactly one cycle at the pipeline end,
// in the order the queries were accepted.
// A query can follow a write to the same word in the very next cycle.
// Pipeline: address and store read, funnel shift and mask, complement and
// group reversal, alignment and minimum. The three store reads of a query go
// to three copies of the store, each with one write and one read port.
// Registers are written through the cfg channel (cfg_ready is always high)
// and may only be changed while no query is in flight.
// Reset clears the pipeline valid bits and loads the register defaults; the
// store contents are undefined until written.
// The receiver cannot stall: every result is a transfer in its own cycle.
module canonical_kmer_extract import cke_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  logic [11:0]           word_index,
	input  logic [WORD_W-1:0]     word_data,
	input  logic [OFFSET_W-1:0]   symbol_offset,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [KMER_W-1:0]     cfg_data,
	output logic                  done,
	output logic [KMER_W-1:0]     canonical_kmer
);

	// configuration registers
	logic [SYM_W-1:0]  symbol_bits_q;
	logic [LEN_W-1:0]  kmer_length_q;
	logic [KMER_W-1:0] kmer_mask_q;
	logic [2:0]        bsel_q;
	logic [5:0]        align_q;

	logic              accept;
	logic              wr_en;
	logic              qry_en;
	logic [3:0]        b_eff;
	logic [9:0]        used;
	logic [BITPOS_W-1:0] bitpos;
	logic [SEQ_ADDR_W-1:0] addr0;
	logic [SEQ_ADDR_W-1:0] addr1;
	logic [SEQ_ADDR_W-1:0] addr2;

	logic              valid_s1;
	logic [4:0]        bit_s1;
	logic [WORD_W-1:0] w0_s1;
	logic [WORD_W-1:0] w1_s1;
	logic [WORD_W-1:0] w2_s1;
	logic [3*WORD_W-1:0] window;

	logic              valid_s2;
	logic [KMER_W-1:0] fwd_s2;
	logic [KMER_W-1:0] comp;
	logic [KMER_W-1:0] rev_opt [MAX_SYM];

	logic              valid_s3;
	logic [KMER_W-1:0] fwd_s3;
	logic [KMER_W-1:0] rev_s3;
	logic [KMER_W-1:0] rev_marked;

	logic              valid_s4;
	logic [KMER_W-1:0] result_s4;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign wr_en     = accept && (action == ACT_WRITE);
	assign qry_en    = accept && (action == ACT_QUERY);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_bits_q <= SYMBOL_BITS_RST;
			kmer_length_q <= KMER_LENGTH_RST;
			kmer_mask_q   <= KMER_MASK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SYMBOL_BITS: symbol_bits_q <= cfg_data[SYM_W-1:0];
				CFG_KMER_LENGTH: kmer_length_q <= cfg_data[LEN_W-1:0];
				CFG_KMER_MASK:   kmer_mask_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// symbol width clamped to one through eight
	always_comb begin
		if (symbol_bits_q == 4'd0) begin
			b_eff = 4'd1;
		end else if (symbol_bits_q > 4'd8) begin
			b_eff = 4'd8;
		end else begin
			b_eff = symbol_bits_q;
		end
	end

	// alignment of the reverse complement, settled from the registers
	assign used = 10'(b_eff * ({4'b0000, kmer_length_q} + 10'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsel_q  <= 3'd1;
			align_q <= 6'd0;
		end else begin
			bsel_q  <= 3'(b_eff - 4'd1);
			align_q <= (used <= 10'd64) ? 6'(10'd64 - used) : 6'd0;
		end
	end

	// stage 0: bit position and the three word addresses
	assign bitpos = BITPOS_W'(symbol_offset) * BITPOS_W'(b_eff);
	assign addr0  = bitpos[SEQ_ADDR_W+4:5];
	assign addr1  = addr0 + SEQ_ADDR_W'(1);
	assign addr2  = addr0 + SEQ_ADDR_W'(2);

	cke_ram #(.WIDTH(WORD_W), .DEPTH(SEQ_WORDS)) u_ram0 (
		.clk   (clk),
		.we    (wr_en),
		.waddr (word_index[SEQ_ADDR_W-1:0]),
		.wdata (word_data),
		.raddr (addr0),
		.rdata (w0_s1)
	);

	cke_ram #(.WIDTH(WORD_W), .DEPTH(SEQ_WORDS)) u_ram1 (
		.clk   (clk),
		.we    (wr_en),
		.waddr (word_index[SEQ_ADDR_W-1:0]),
		.wdata (word_data),
		.raddr (addr1),
		.rdata (w1_s1)
	);

	cke_ram #(.WIDTH(WORD_W), .DEPTH(SEQ_WORDS)) u_ram2 (
		.clk   (clk),
		.we    (wr_en),
		.waddr (word_index[SEQ_ADDR_W-1:0]),
		.wdata (word_data),
		.raddr (addr2),
		.rdata (w2_s1)
	);

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= qry_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 1: funnel shift of three words and the mask
	assign window = {w0_s1, w1_s1, w2_s1} << bit_s1;

	always_ff @(posedge clk) begin
		bit_s1 <= bitpos[4:0];
		fwd_s2 <= window[3*WORD_W-1:WORD_W] & kmer_mask_q;
	end

	// stage 2: complement and reversal in groups, one wiring per width
	assign comp = ~fwd_s2;

	for (genvar gb = 1; gb <= MAX_SYM; gb++) begin : g_width
		for (genvar gp = 0; gp < KMER_W; gp++) begin : g_bit
			localparam int NGRP = (KMER_W + gb - 1) / gb;
			localparam int GRP  = NGRP - gp / gb;
			localparam int SRC  = GRP * gb + gp % gb;
			if (gp >= gb && SRC < KMER_W) begin : g_map
				assign rev_opt[gb-1][gp] = comp[SRC];
			end else begin : g_zero
				assign rev_opt[gb-1][gp] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_s3 <= fwd_s2;
		rev_s3 <= rev_opt[bsel_q];
	end

	// stage 3: align, mark and keep the smaller value
	assign rev_marked = (rev_s3 << align_q) | KMER_W'(1);

	always_ff @(posedge clk) begin
		result_s4 <= (fwd_s3 < rev_marked) ? fwd_s3 : rev_marked;
	end

	assign done           = valid_s4;
	assign canonical_kmer = result_s4;

	// every accepted query comes out as a result
	a_query_result: assert property (@(posedge clk) disable iff (!arst_n)
		qry_en |-> ##4 done)
		else $error("query accepted without a result four cycles later");

	// no result without an earlier accepted query
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(qry_en, 4))
		else $error("result without a matching query");

	// a result other than the forward value carries the mark bit
	a_rev_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(done && canonical_kmer != $past(fwd_s3)) |-> canonical_kmer[0])
		else $error("reverse complement result without mark bit");

	// writes never produce a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !$past(qry_en, 3)) |=> ##3 !done)
		else $error("write produced a result");

endmodule
